FILE: hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// Shared widths, register indexes and reset values of the periodic
// trilinear grid sampler.
// ----------------------------------------------------------------------------
package pts_pkg;

    // payload widths
    localparam int SAMPLE_W = 32;   // Q16.16 sample and position
    localparam int DIFF_W   = 33;   // position minus origin
    localparam int COEF_W   = 18;   // Q4.14 matrix term
    localparam int ROW_W    = 54;   // three packed terms
    localparam int PROD_W   = 51;   // matrix term times difference
    localparam int ACC_W    = 53;   // grid coordinate, 30 fraction bits
    localparam int FRAC_W   = 16;   // Q0.16 weight
    localparam int DIMF_W   = 6;    // one packed size field
    localparam int DIMS_W   = 18;
    localparam int CELL_W   = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W    = 54;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_DIMS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW_X = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW_Y = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_ROW_Z = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd6;

    // input kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // reset values: 1x1x1 grid, identity matrix
    localparam logic [DIMS_W-1:0] DIMS_RST  = 18'd4161;
    localparam logic [ROW_W-1:0]  ROW_X_RST = 54'd16384;
    localparam logic [ROW_W-1:0]  ROW_Y_RST = 54'd16384 << 18;
    localparam logic [ROW_W-1:0]  ROW_Z_RST = 54'd16384 << 36;

    // rounding constant for the blend, half a Q16.16 LSB at the product scale
    localparam logic signed [PROD_W-1:0] HALF = 51'sd32768;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [FRAC_W-1:0]          t_frac;
    typedef logic [DIMF_W-1:0]          t_dim;

endpackage

FILE: hdl/periodic_trilinear_grid_sampler.sv
// ----------------------------------------------------------------------------
// periodic_trilinear_grid_sampler
// Stores a periodic 3D grid of Q16.16 samples and returns the trilinear
// blend of the eight corner samples around a world position.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                    payload
//  input    in         i_in_valid / o_in_ready      i_kind, i_cell_*, i_sample_value, i_pos_*
//  output   out        o_out_valid / i_out_ready    o_potential
//  config   in         i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
//  A write transaction goes straight to the store; a query passes through the
//  shared coordinate multiplier, the 8-bit-a-cycle remainder unit, the grid
//  memory read port and the shared blend multiplier, in that order.
//  After reset all 2**(3*clog2(MAX_DIM)) grid memory entries (32768 at MAX_DIM = 32)
//  are zeroed, one entry a cycle; no input is taken then.
//  A query waits to leave only while the output register still holds an
//  untaken result; a new transaction is accepted while that result waits.
// ----------------------------------------------------------------------------
module periodic_trilinear_grid_sampler #(
    parameter int MAX_DIM = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [pts_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pts_pkg::CFG_W-1:0]          i_cfg_data,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_kind,
    input  logic [pts_pkg::CELL_W-1:0]         i_cell_i,
    input  logic [pts_pkg::CELL_W-1:0]         i_cell_j,
    input  logic [pts_pkg::CELL_W-1:0]         i_cell_k,
    input  logic signed [pts_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic signed [pts_pkg::SAMPLE_W-1:0] i_pos_x,
    input  logic signed [pts_pkg::SAMPLE_W-1:0] i_pos_y,
    input  logic signed [pts_pkg::SAMPLE_W-1:0] i_pos_z,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [pts_pkg::SAMPLE_W-1:0] o_potential
);

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = 3 * IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_BLEND = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // configuration registers
    logic [pts_pkg::DIMS_W-1:0] r_dims;
    logic [pts_pkg::ROW_W-1:0]  r_row_x, r_row_y, r_row_z;
    pts_pkg::t_sample           r_org_x, r_org_y, r_org_z;

    // sequencer
    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt;
    logic [1:0] r_row, r_term, r_prow, r_coord;
    logic       r_ph;

    // datapath
    logic signed [pts_pkg::DIFF_W-1:0] r_dx, r_dy, r_dz;
    logic signed [pts_pkg::PROD_W-1:0] r_prod;
    pts_pkg::t_acc                     r_acc [3];
    logic [pts_pkg::DIMF_W-1:0]        r_rem;
    logic [IDX_W-1:0]                  r_lo [3];
    logic [IDX_W-1:0]                  r_hi [3];
    pts_pkg::t_frac                    r_frac [3];
    pts_pkg::t_sample                  r_q [8];
    logic                              r_out_valid;
    pts_pkg::t_sample                  r_pot;

    // memory interface
    logic             w_mem_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    pts_pkg::t_sample w_rdata;
    logic             w_busy;

    logic w_acc_in, w_cell_ok;

    // effective size of one axis, 1..MAX_DIM
    function automatic pts_pkg::t_dim dim_of(input pts_pkg::t_dim f);
        pts_pkg::t_dim d;
        d = f;
        if (f == '0) begin
            d = pts_pkg::DIMF_W'(1);
        end else if (int'(f) > MAX_DIM) begin
            d = pts_pkg::DIMF_W'(MAX_DIM);
        end
        return d;
    endfunction

    pts_pkg::t_dim w_dim [3];
    assign w_dim[0] = dim_of(r_dims[5:0]);
    assign w_dim[1] = dim_of(r_dims[11:6]);
    assign w_dim[2] = dim_of(r_dims[17:12]);

    assign o_in_ready  = (r_state == S_IDLE) && !w_busy;
    assign w_acc_in    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_potential = r_pot;

    // write transactions go straight to the store
    assign w_cell_ok = (int'(i_cell_i) < MAX_DIM) && (int'(i_cell_j) < MAX_DIM)
                    && (int'(i_cell_k) < MAX_DIM);
    assign w_mem_we  = w_acc_in && (i_kind == pts_pkg::KIND_WRITE) && w_cell_ok;
    assign w_waddr   = {IDX_W'(i_cell_i), IDX_W'(i_cell_j), IDX_W'(i_cell_k)};

    // coordinate multiplier operands
    logic [pts_pkg::ROW_W-1:0]         w_rowsel;
    logic signed [pts_pkg::COEF_W-1:0] w_coef;
    logic signed [pts_pkg::DIFF_W-1:0] w_dsel;
    logic signed [pts_pkg::PROD_W-1:0] w_mprod;

    always_comb begin
        unique case (r_row)
            2'd0:    w_rowsel = r_row_x;
            2'd1:    w_rowsel = r_row_y;
            default: w_rowsel = r_row_z;
        endcase
        unique case (r_term)
            2'd0: begin
                w_coef = w_rowsel[17:0];
                w_dsel = r_dx;
            end
            2'd1: begin
                w_coef = w_rowsel[35:18];
                w_dsel = r_dy;
            end
            default: begin
                w_coef = w_rowsel[53:36];
                w_dsel = r_dz;
            end
        endcase
    end
    assign w_mprod = w_coef * w_dsel;

    // remainder unit: floor index modulo axis size, eight bits a cycle
    pts_pkg::t_acc  w_g;
    logic           w_neg;
    logic [23:0]    w_vpad;
    logic [7:0]     w_chunk;
    pts_pkg::t_dim  w_n, w_rem, w_lo, w_hi;
    logic [6:0]     w_r7, w_lo1;

    always_comb begin
        w_g    = r_acc[r_coord];
        w_neg  = w_g[52];
        w_vpad = {2'b00, (w_neg ? ~w_g[51:30] : w_g[51:30])};
        w_n    = w_dim[r_coord];
        unique case (r_cnt[1:0])
            2'd0:    w_chunk = w_vpad[23:16];
            2'd1:    w_chunk = w_vpad[15:8];
            default: w_chunk = w_vpad[7:0];
        endcase
        w_rem = (r_cnt == 4'd0) ? '0 : r_rem;
        for (int b = 7; b >= 0; b--) begin
            w_r7 = {w_rem, w_chunk[b]};
            if (w_r7 >= {1'b0, w_n}) begin
                w_r7 = w_r7 - {1'b0, w_n};
            end
            w_rem = w_r7[5:0];
        end
        w_lo  = w_neg ? (w_n - 6'd1 - w_rem) : w_rem;
        w_lo1 = {1'b0, w_lo} + 7'd1;
        w_hi  = (w_lo1 >= {1'b0, w_n}) ? '0 : w_lo1[5:0];
    end

    // corner address: x select in bit 0, y in bit 1, z in bit 2
    assign w_raddr = {(r_cnt[0] ? r_hi[0] : r_lo[0]),
                      (r_cnt[1] ? r_hi[1] : r_lo[1]),
                      (r_cnt[2] ? r_hi[2] : r_lo[2])};

    // blend unit: a + round((b - a) * f)
    pts_pkg::t_frac                    w_f;
    logic signed [pts_pkg::DIFF_W-1:0] w_bdiff;
    logic signed [pts_pkg::PROD_W-1:0] w_bprod, w_rnd;
    logic signed [35:0]                w_bsum;
    pts_pkg::t_sample                  w_bres;
    logic [2:0]                        w_tail;

    always_comb begin
        if (r_cnt < 4'd4) begin
            w_f = r_frac[0];
        end else if (r_cnt < 4'd6) begin
            w_f = r_frac[1];
        end else begin
            w_f = r_frac[2];
        end
        w_bdiff = pts_pkg::DIFF_W'(r_q[1]) - pts_pkg::DIFF_W'(r_q[0]);
        w_bprod = w_bdiff * $signed({1'b0, w_f});
        w_rnd   = (r_prod + pts_pkg::HALF) >>> 16;
        w_bsum  = 36'(r_q[0]) + 36'(w_rnd);
        if (w_bsum > 36'sh07FFFFFFF) begin
            w_bres = 32'sh7FFFFFFF;
        end else if (w_bsum < -36'sh080000000) begin
            w_bres = -32'sh80000000;
        end else begin
            w_bres = w_bsum[31:0];
        end
        w_tail = 3'(4'd6 - r_cnt);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_acc_in && i_kind == pts_pkg::KIND_QUERY) n_state = S_MAC;
            S_MAC:   if (r_cnt == 4'd9) n_state = S_MOD;
            S_MOD:   if (r_cnt == 4'd2 && r_coord == 2'd2) n_state = S_READ;
            S_READ:  if (r_cnt == 4'd8) n_state = S_BLEND;
            S_BLEND: if (r_ph && r_cnt == 4'd6) n_state = S_OUT;
            S_OUT:   if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_row       <= '0;
            r_term      <= '0;
            r_coord     <= '0;
            r_ph        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // output register: set when a result leaves, cleared when taken
            if (r_state == S_OUT && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt  <= '0;
                    r_row  <= '0;
                    r_term <= '0;
                end
                S_MAC: begin
                    if (r_cnt == 4'd9) begin
                        r_cnt   <= '0;
                        r_coord <= '0;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                        if (r_term == 2'd2) begin
                            r_term <= '0;
                            r_row  <= r_row + 2'd1;
                        end else begin
                            r_term <= r_term + 2'd1;
                        end
                    end
                end
                S_MOD: begin
                    if (r_cnt == 4'd2) begin
                        r_cnt   <= '0;
                        r_coord <= r_coord + 2'd1;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_READ: begin
                    if (r_cnt == 4'd8) begin
                        r_cnt <= '0;
                        r_ph  <= 1'b0;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_BLEND: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims  <= pts_pkg::DIMS_RST;
            r_row_x <= pts_pkg::ROW_X_RST;
            r_row_y <= pts_pkg::ROW_Y_RST;
            r_row_z <= pts_pkg::ROW_Z_RST;
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pts_pkg::CFG_GRID_DIMS: r_dims  <= i_cfg_data[17:0];
                pts_pkg::CFG_INV_ROW_X: r_row_x <= i_cfg_data;
                pts_pkg::CFG_INV_ROW_Y: r_row_y <= i_cfg_data;
                pts_pkg::CFG_INV_ROW_Z: r_row_z <= i_cfg_data;
                pts_pkg::CFG_ORIGIN_X:  r_org_x <= i_cfg_data[31:0];
                pts_pkg::CFG_ORIGIN_Y:  r_org_y <= i_cfg_data[31:0];
                pts_pkg::CFG_ORIGIN_Z:  r_org_z <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_dx <= pts_pkg::DIFF_W'(i_pos_x) - pts_pkg::DIFF_W'(r_org_x);
                r_dy <= pts_pkg::DIFF_W'(i_pos_y) - pts_pkg::DIFF_W'(r_org_y);
                r_dz <= pts_pkg::DIFF_W'(i_pos_z) - pts_pkg::DIFF_W'(r_org_z);
                for (int c = 0; c < 3; c++) begin
                    r_acc[c] <= '0;
                end
            end
            S_MAC: begin
                if (r_cnt != 4'd9) begin
                    r_prod <= w_mprod;
                    r_prow <= r_row;
                end
                if (r_cnt != 4'd0) begin
                    r_acc[r_prow] <= r_acc[r_prow] + pts_pkg::ACC_W'(r_prod);
                end
            end
            S_MOD: begin
                r_rem <= w_rem;
                if (r_cnt == 4'd2) begin
                    r_lo[r_coord]   <= IDX_W'(w_lo);
                    r_hi[r_coord]   <= IDX_W'(w_hi);
                    r_frac[r_coord] <= w_g[29:14];
                end
            end
            S_READ: begin
                if (r_cnt != 4'd0) begin
                    for (int i = 0; i < 7; i++) begin
                        r_q[i] <= r_q[i+1];
                    end
                    r_q[7] <= w_rdata;
                end
            end
            S_BLEND: begin
                if (!r_ph) begin
                    r_prod <= w_bprod;
                end else begin
                    // drop the blended pair, blended value lands at the tail
                    for (int i = 0; i < 6; i++) begin
                        r_q[i] <= (3'(i) == w_tail) ? w_bres : r_q[i+2];
                    end
                    if (w_tail == 3'd6) begin
                        r_q[6] <= w_bres;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    r_pot <= r_q[0];
                end
            end
            default: ;
        endcase
    end

    pts_grid_mem #(
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (w_mem_we),
        .i_waddr (w_waddr),
        .i_wdata (i_sample_value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata),
        .o_busy  (w_busy)
    );

    // no transaction is taken while the store is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_in_ready)
        else $error("input accepted during clearing sweep");

    // a query starts the coordinate multiply
    a_query_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc_in && i_kind == pts_pkg::KIND_QUERY) |=> (r_state == S_MAC && r_cnt == 4'd0))
        else $error("query did not start the multiply phase");

    // a new result appears only out of the output state
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result raised outside output state");

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> $stable(r_pot))
        else $error("pending result overwritten");

endmodule

FILE: hdl/pts_grid_mem.sv
// ----------------------------------------------------------------------------
// pts_grid_mem
// Grid sample store: one write port, one registered read port, and a
// clearing sweep after reset that zeroes every entry.
// ----------------------------------------------------------------------------
module pts_grid_mem #(
    parameter int ADDR_W = 15
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_we,
    input  logic [ADDR_W-1:0]      i_waddr,
    input  pts_pkg::t_sample       i_wdata,
    input  logic [ADDR_W-1:0]      i_raddr,
    output pts_pkg::t_sample       o_rdata,
    output logic                   o_busy
);

    localparam int DEPTH = 1 << ADDR_W;

    pts_pkg::t_sample r_mem [DEPTH];
    pts_pkg::t_sample r_rdata;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_busy;

    // clearing sweep, one entry a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // write port, shared by the sweep
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule
